FILE: src/scpr_pkg.sv
// ----------------------------------------------------------------------------
// Second-chance page replacement: shared package
// Cell control and status bundles, controller states and fixed widths.
// ----------------------------------------------------------------------------
package scpr_pkg;

  // Frame limit register
  localparam int          FRAMES_W     = 4;
  localparam logic [3:0]  FRAMES_RESET = 4'd3;

  // Saturating totals
  localparam int CNT_W = 32;

  // Per-cell control from the controller
  typedef struct packed {
    logic hit_set;  // lookup hit: set reference bit on match
    logic fill;     // miss with free frame: load this cell
    logic sweep;    // hand is on this cell during a sweep
  } cell_ctl_t;

  // Per-cell status toward the controller
  typedef struct packed {
    logic match;    // resident page equals the key
    logic evict;    // hand here and reference bit clear
  } cell_stat_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_RESP
  } state_e;

endpackage

FILE: src/scpr_cell.sv
// ----------------------------------------------------------------------------
// Second-chance page replacement: frame cell
// Holds one resident page with its valid and reference bits, compares it
// against the key and applies hit, fill and sweep updates.
// ----------------------------------------------------------------------------
module scpr_cell import scpr_pkg::*; #(
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctl_t            ctl_i,
  input  logic [PAGE_BITS-1:0] key_i,
  output cell_stat_t           stat_o,
  output logic [PAGE_BITS-1:0] page_o
);

  logic                 valid_q;
  logic                 ref_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 replace;

  // Compare and eviction status
  assign stat_o.match = valid_q && (page_q == key_i);
  assign stat_o.evict = ctl_i.sweep && !ref_q;
  assign replace      = ctl_i.fill || (ctl_i.sweep && !ref_q);
  assign page_o       = page_q;

  // Valid and reference bits; a swept cell either loses its second chance
  // or is replaced and comes back with the bit set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
    end else if (ctl_i.fill) begin
      valid_q <= 1'b1;
      ref_q   <= 1'b1;
    end else if (ctl_i.hit_set && stat_o.match) begin
      ref_q <= 1'b1;
    end else if (ctl_i.sweep) begin
      ref_q <= ~ref_q;
    end
  end

  // Page storage
  always_ff @(posedge clk_i) begin
    if (replace) begin
      page_q <= key_i;
    end
  end

endmodule

FILE: src/second_chance_page_replacement_core.sv
// ----------------------------------------------------------------------------
// Second-chance page replacement core
// Row of frame cells with a one-hot clock hand passed cell to cell.
// ----------------------------------------------------------------------------
// Each request is one page reference and yields one result. A hit or the fill
// of a free frame goes from lookup straight to the response state; when all
// frames are full a sweep runs in between, in which the clock hand visits k
// cells (1 to occupied frames + 1): the hand moves one cell per cycle, clearing
// reference bits until it reaches a cell whose bit is clear. Lookup compares
// all cells at once. A new request is taken once the previous result has
// been placed in the output register; that register may still be waiting.
// A frame limit of 0 acts as 1 and values above MAX_FRAMES act as MAX_FRAMES.
module second_chance_page_replacement_core import scpr_pkg::*; #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [FRAMES_W-1:0]  cfg_wdata_i,
  // request
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PAGE_BITS-1:0] page_number_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [CNT_W-1:0]     hit_total_o,
  output logic [CNT_W-1:0]     fault_total_o
);

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int LW = (CW > FRAMES_W) ? CW : FRAMES_W;

  state_e                state_q, state_d;
  logic [FRAMES_W-1:0]   frames_q;
  logic [PAGE_BITS-1:0]  key_q;
  logic [CW-1:0]         occ_q;
  logic [MAX_FRAMES-1:0] tok_q, tok_next;
  logic [CNT_W-1:0]      hit_cnt_q, fault_cnt_q;
  logic                  hit_q, ev_valid_q;
  logic [PAGE_BITS-1:0]  ev_page_q;

  logic                  out_valid_q, out_hit_q, out_ev_valid_q;
  logic [PAGE_BITS-1:0]  out_ev_page_q;
  logic [CNT_W-1:0]      out_hit_total_q, out_fault_total_q;

  cell_ctl_t             ctl   [MAX_FRAMES];
  cell_stat_t            stat  [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  pages [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] match_vec, evict_vec, last_vec;

  logic                  accept, out_free, any_match, any_evict, full;
  logic [LW-1:0]         frames_ext, limit;
  logic [PAGE_BITS-1:0]  sweep_page;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Effective frame limit, clamped to 1..MAX_FRAMES
  always_comb begin
    frames_ext = LW'(frames_q);
    if (frames_ext == '0) begin
      limit = LW'(1);
    end else if (frames_ext > LW'(MAX_FRAMES)) begin
      limit = LW'(MAX_FRAMES);
    end else begin
      limit = frames_ext;
    end
  end
  assign full = (LW'(occ_q) >= limit);

  // Cell row
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign ctl[i].hit_set = (state_q == ST_LOOK) && any_match;
    assign ctl[i].fill    = (state_q == ST_LOOK) && !any_match && !full
                            && (occ_q == CW'(i));
    assign ctl[i].sweep   = (state_q == ST_SWEEP) && tok_q[i];
    assign match_vec[i]   = stat[i].match;
    assign evict_vec[i]   = stat[i].evict;
    assign last_vec[i]    = (CW'(i) == occ_q - CW'(1));

    scpr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl[i]),
      .key_i (key_q),
      .stat_o(stat[i]),
      .page_o(pages[i])
    );

    // Hand passes to the neighbor; the last occupied cell wraps to cell 0
    if (i == 0) begin : g_wrap
      assign tok_next[i] = |(tok_q & last_vec);
    end else begin : g_pass
      assign tok_next[i] = tok_q[i-1] && !last_vec[i-1];
    end
  end

  assign any_match = |match_vec;
  assign any_evict = |evict_vec;

  // Page leaving the cell under the hand
  always_comb begin
    sweep_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (evict_vec[i]) begin
        sweep_page = sweep_page | pages[i];
      end
    end
  end

  // Controller next state
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!any_match && full) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SWEEP: begin
        if (any_evict) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // Request key
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= page_number_i;
    end
  end

  // Occupancy, hand, totals and per-request outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      tok_q       <= MAX_FRAMES'(1);
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      hit_q       <= 1'b0;
      ev_valid_q  <= 1'b0;
      ev_page_q   <= '0;
    end else begin
      if (state_q == ST_LOOK) begin
        hit_q      <= any_match;
        ev_valid_q <= 1'b0;
        ev_page_q  <= '0;
        if (any_match) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + CNT_W'(1);
          end
        end else begin
          if (fault_cnt_q != '1) begin
            fault_cnt_q <= fault_cnt_q + CNT_W'(1);
          end
          if (!full) begin
            occ_q <= occ_q + CW'(1);
          end
        end
      end
      if (state_q == ST_SWEEP) begin
        tok_q <= tok_next;
        if (any_evict) begin
          ev_valid_q <= 1'b1;
          ev_page_q  <= sweep_page;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RESP) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESP) && out_free) begin
      out_hit_q         <= hit_q;
      out_ev_valid_q    <= ev_valid_q;
      out_ev_page_q     <= ev_page_q;
      out_hit_total_q   <= hit_cnt_q;
      out_fault_total_q <= fault_cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = out_ev_page_q;
  assign hit_total_o     = out_hit_total_q;
  assign fault_total_o   = out_fault_total_q;

`ifndef ASSERT_OFF
  // Exactly one cell holds the clock hand
  a_hand_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tok_q))
    else $error("clock hand not one-hot");

  // Occupancy never exceeds the frame row
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(MAX_FRAMES))
    else $error("occupancy beyond frame count");

  // A new result only comes from the response state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result without response state");

  // Sweeps only run with a non-empty row
  a_sweep_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (occ_q != '0))
    else $error("sweep over empty row");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_ev_valid_q))
    else $error("hit with eviction");
`endif

endmodule
